### rtl/core/tgm_pkg.sv
// shared constants, types and codes for the tilt gesture morse recorder
package tgm_pkg;

	localparam int BUFFER_DEPTH = 128;
	localparam int SAMPLE_WIDTH = 16;

	localparam int ADDR_W     = $clog2(BUFFER_DEPTH);
	localparam int BANK_DEPTH = (BUFFER_DEPTH + 1) / 2;
	localparam int BANK_AW    = ADDR_W - 1;

	localparam int MODE_W    = 2;
	localparam int IDX_W     = 7;
	localparam int LEN_OUT_W = 7;
	localparam int CHAR_W    = 8;
	localparam int THR_W     = 15;
	localparam int ALPHA_W   = 9;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;

	// widths for index/length compares and for magnitude compares
	localparam int IDX_XW = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
	localparam int CMP_W  = ((SAMPLE_WIDTH + 1) > THR_W) ? (SAMPLE_WIDTH + 1) : THR_W;

	localparam logic [CFG_IDX_W-1:0] REG_MAIN_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORTHO_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA    = 2'd2;

	localparam logic [THR_W-1:0]   MAIN_THR_RESET  = 15'd6144;
	localparam logic [THR_W-1:0]   ORTHO_THR_RESET = 15'd2867;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 9'd51;
	localparam logic [ALPHA_W-1:0] ALPHA_FULL      = 9'd256;

	localparam logic signed [SAMPLE_WIDTH-1:0] FY_RESET = '0;
	localparam logic signed [SAMPLE_WIDTH-1:0] FZ_RESET = SAMPLE_WIDTH'(8192);

	localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SENT = 2'd2;

	localparam logic [1:0] STATE_IDLE  = 2'd0;
	localparam logic [1:0] STATE_REC   = 2'd1;
	localparam logic [1:0] STATE_READY = 2'd2;

	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

	typedef enum logic [1:0] {
		GEST_NONE = 2'd0,
		GEST_DOT  = 2'd1,
		GEST_DASH = 2'd2
	} pose_t;

	typedef struct packed {
		logic               en;
		logic [BANK_AW-1:0] addr;
		logic [CHAR_W-1:0]  data;
	} bank_wr_t;

	typedef struct packed {
		logic               en;
		logic [BANK_AW-1:0] addr;
		logic               sel;
		logic               ok;
	} rd_req_t;

	typedef struct packed {
		logic [1:0]           app_state;
		logic [1:0]           chars_added;
		logic [CHAR_W-1:0]    first_char;
		logic [CHAR_W-1:0]    second_char;
		logic [LEN_OUT_W-1:0] message_length;
	} res_t;

endpackage

### rtl/core/tilt_gesture_morse_recorder.sv
// top level: configuration registers, two-bank message buffer and result pipeline
// pipeline: two register stages, s1 and the result registers; a stalled result
// stage holds s1, so a result is shown once it has passed both
// throughput: one request per cycle while the result stage is not stalled; the
// state updates on each accepted request and the buffer banks have registered reads
// reset: control, button history, pose and filter state clear at once; the
// buffer is not cleared, only bytes below the held length are ever read
module tilt_gesture_morse_recorder (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [tgm_pkg::MODE_W-1:0]              mode,
	input  logic signed [tgm_pkg::SAMPLE_WIDTH-1:0] accel_y,
	input  logic signed [tgm_pkg::SAMPLE_WIDTH-1:0] accel_z,
	input  logic                                    sample_ok,
	input  logic                                    start_button,
	input  logic                                    space_button,
	input  logic [tgm_pkg::IDX_W-1:0]               read_index,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [1:0]                              app_state,
	output logic [1:0]                              chars_added,
	output logic [tgm_pkg::CHAR_W-1:0]              first_char,
	output logic [tgm_pkg::CHAR_W-1:0]              second_char,
	output logic [tgm_pkg::LEN_OUT_W-1:0]           message_length,
	output logic [tgm_pkg::CHAR_W-1:0]              read_byte,
	input  logic                                    cfg_we,
	input  logic [tgm_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [tgm_pkg::CFG_W-1:0]               cfg_data
);
	import tgm_pkg::*;

	logic [THR_W-1:0]   main_thr_q;
	logic [THR_W-1:0]   ortho_thr_q;
	logic [ALPHA_W-1:0] alpha_q;

	logic               accept;
	logic               adv_s1;
	bank_wr_t           wr_even;
	bank_wr_t           wr_odd;
	rd_req_t            rd_req;
	res_t               res;
	logic [CHAR_W-1:0]  rdata_even;
	logic [CHAR_W-1:0]  rdata_odd;

	logic               valid_s1;
	res_t               res_s1;
	logic               rd_ok_s1;
	logic               rd_sel_s1;
	logic [CHAR_W-1:0]  rbyte_s1;

	logic               out_valid_q;
	res_t               res_q;
	logic [CHAR_W-1:0]  read_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_thr_q  <= MAIN_THR_RESET;
			ortho_thr_q <= ORTHO_THR_RESET;
			alpha_q     <= ALPHA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAIN_THRESHOLD:  main_thr_q  <= cfg_data[THR_W-1:0];
				REG_ORTHO_THRESHOLD: ortho_thr_q <= cfg_data[THR_W-1:0];
				REG_FILTER_ALPHA:    alpha_q     <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// a new request enters while s1 or the result stage is empty, or the result moves on
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	tgm_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.mode            (mode),
		.accel_y         (accel_y),
		.accel_z         (accel_z),
		.sample_ok       (sample_ok),
		.start_button    (start_button),
		.space_button    (space_button),
		.read_index      (read_index),
		.filter_alpha    (alpha_q),
		.main_threshold  (main_thr_q),
		.ortho_threshold (ortho_thr_q),
		.wr_even         (wr_even),
		.wr_odd          (wr_odd),
		.rd_req          (rd_req),
		.res             (res)
	);

	tgm_ram #(
		.DEPTH (BANK_DEPTH),
		.WIDTH (CHAR_W),
		.AW    (BANK_AW)
	) u_ram_even (
		.clk   (clk),
		.we    (accept && wr_even.en),
		.waddr (wr_even.addr),
		.wdata (wr_even.data),
		.re    (rd_req.en),
		.raddr (rd_req.addr),
		.rdata (rdata_even)
	);

	tgm_ram #(
		.DEPTH (BANK_DEPTH),
		.WIDTH (CHAR_W),
		.AW    (BANK_AW)
	) u_ram_odd (
		.clk   (clk),
		.we    (accept && wr_odd.en),
		.waddr (wr_odd.addr),
		.wdata (wr_odd.data),
		.re    (rd_req.en),
		.raddr (rd_req.addr),
		.rdata (rdata_odd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1    <= res;
			rd_ok_s1  <= rd_req.ok;
			rd_sel_s1 <= rd_req.sel;
		end
	end

	// ram data holds until the next request, which only comes once s1 has moved on
	assign rbyte_s1 = rd_ok_s1 ? (rd_sel_s1 ? rdata_odd : rdata_even) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q       <= res_s1;
			read_byte_q <= rbyte_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign app_state      = res_q.app_state;
	assign chars_added    = res_q.chars_added;
	assign first_char     = res_q.first_char;
	assign second_char    = res_q.second_char;
	assign message_length = res_q.message_length;
	assign read_byte      = read_byte_q;

endmodule

### rtl/core/tgm_ram.sv
// generic single write port, single read port ram with registered read data
module tgm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/tgm_filter.sv
// ema filter on both axes and dot/dash pose classification
module tgm_filter (
	input  logic signed [tgm_pkg::SAMPLE_WIDTH-1:0] fy,
	input  logic signed [tgm_pkg::SAMPLE_WIDTH-1:0] fz,
	input  logic signed [tgm_pkg::SAMPLE_WIDTH-1:0] accel_y,
	input  logic signed [tgm_pkg::SAMPLE_WIDTH-1:0] accel_z,
	input  logic                                    sample_ok,
	input  logic [tgm_pkg::ALPHA_W-1:0]             filter_alpha,
	input  logic [tgm_pkg::THR_W-1:0]               main_threshold,
	input  logic [tgm_pkg::THR_W-1:0]               ortho_threshold,
	output logic signed [tgm_pkg::SAMPLE_WIDTH-1:0] fy_next,
	output logic signed [tgm_pkg::SAMPLE_WIDTH-1:0] fz_next,
	output tgm_pkg::pose_t                          pose
);
	import tgm_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam logic signed [SW+10:0] ROUND = 128;

	logic [ALPHA_W-1:0]      a;
	logic [ALPHA_W-1:0]      b;
	logic signed [SW+9:0]    pay_new;
	logic signed [SW+9:0]    pay_old;
	logic signed [SW+9:0]    paz_new;
	logic signed [SW+9:0]    paz_old;
	logic signed [SW+10:0]   sum_y;
	logic signed [SW+10:0]   sum_z;
	logic signed [SW-1:0]    cy;
	logic signed [SW-1:0]    cz;
	logic [CMP_W-1:0]        mag_y;
	logic [CMP_W-1:0]        mag_z;
	logic [CMP_W-1:0]        thr_main;
	logic [CMP_W-1:0]        thr_ortho;

	function automatic logic [CMP_W-1:0] mag(input logic signed [SW-1:0] v);
		logic [SW:0] m;
		m = v[SW-1] ? ((SW+1)'(0) - {v[SW-1], v}) : {1'b0, v};
		return CMP_W'(m);
	endfunction

	// weights above full scale count as full scale
	assign a = (filter_alpha > ALPHA_FULL) ? ALPHA_FULL : filter_alpha;
	assign b = ALPHA_FULL - a;

	assign pay_new = $signed({1'b0, a}) * accel_y;
	assign pay_old = $signed({1'b0, b}) * fy;
	assign paz_new = $signed({1'b0, a}) * accel_z;
	assign paz_old = $signed({1'b0, b}) * fz;

	assign sum_y = pay_new + pay_old + ROUND;
	assign sum_z = paz_new + paz_old + ROUND;

	// arithmetic shift gives floor division by 256
	assign fy_next = sum_y[SW+7:8];
	assign fz_next = sum_z[SW+7:8];

	assign cy = sample_ok ? fy_next : fy;
	assign cz = sample_ok ? fz_next : fz;

	assign mag_y     = mag(cy);
	assign mag_z     = mag(cz);
	assign thr_main  = CMP_W'(main_threshold);
	assign thr_ortho = CMP_W'(ortho_threshold);

	always_comb begin
		if (mag_z > thr_main && mag_y < thr_ortho) begin
			pose = GEST_DOT;
		end else if (mag_y > thr_main && mag_z < thr_ortho) begin
			pose = GEST_DASH;
		end else begin
			pose = GEST_NONE;
		end
	end

endmodule

### rtl/core/tgm_ctrl.sv
// recorder state machine, append logic and buffer write/read requests
module tgm_ctrl (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    accept,
	input  logic [tgm_pkg::MODE_W-1:0]              mode,
	input  logic signed [tgm_pkg::SAMPLE_WIDTH-1:0] accel_y,
	input  logic signed [tgm_pkg::SAMPLE_WIDTH-1:0] accel_z,
	input  logic                                    sample_ok,
	input  logic                                    start_button,
	input  logic                                    space_button,
	input  logic [tgm_pkg::IDX_W-1:0]               read_index,
	input  logic [tgm_pkg::ALPHA_W-1:0]             filter_alpha,
	input  logic [tgm_pkg::THR_W-1:0]               main_threshold,
	input  logic [tgm_pkg::THR_W-1:0]               ortho_threshold,
	output tgm_pkg::bank_wr_t                       wr_even,
	output tgm_pkg::bank_wr_t                       wr_odd,
	output tgm_pkg::rd_req_t                        rd_req,
	output tgm_pkg::res_t                           res
);
	import tgm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE  = STATE_IDLE,
		S_REC   = STATE_REC,
		S_READY = STATE_READY
	} app_t;

	app_t                     st_q;
	app_t                     st_a;
	app_t                     st_b;
	app_t                     st_n;
	logic [ADDR_W-1:0]        len_q;
	logic [ADDR_W-1:0]        len_a;
	logic [ADDR_W-1:0]        len_c;
	logic [ADDR_W-1:0]        len_n;
	logic [ADDR_W-1:0]        addr1;
	pose_t                    pose_q;
	pose_t                    pose_a;
	pose_t                    pose_b;
	pose_t                    pose_n;
	pose_t                    pose_new;
	logic                     start_prev_q;
	logic                     space_prev_q;
	logic                     last_space_q;
	logic                     last_space_n;
	logic signed [SAMPLE_WIDTH-1:0] fy_q;
	logic signed [SAMPLE_WIDTH-1:0] fz_q;
	logic signed [SAMPLE_WIDTH-1:0] fy_next;
	logic signed [SAMPLE_WIDTH-1:0] fz_next;
	logic                     tick;
	logic                     rise1;
	logic                     rise2;
	logic                     sp_ev;
	logic                     dbl;
	logic                     rec;
	logic                     sym_ev;
	logic                     filt_load;
	logic [CHAR_W-1:0]        sym_ch;
	logic                     c0_v;
	logic                     c1_v;
	logic [CHAR_W-1:0]        c0;
	logic [CHAR_W-1:0]        c1;
	logic                     p0;
	logic                     p1;
	logic [IDX_XW-1:0]        idx_x;
	logic [IDX_XW-1:0]        len_x;

	tgm_filter u_filter (
		.fy              (fy_q),
		.fz              (fz_q),
		.accel_y         (accel_y),
		.accel_z         (accel_z),
		.sample_ok       (sample_ok),
		.filter_alpha    (filter_alpha),
		.main_threshold  (main_threshold),
		.ortho_threshold (ortho_threshold),
		.fy_next         (fy_next),
		.fz_next         (fz_next),
		.pose            (pose_new)
	);

	assign tick  = accept && (mode == MODE_TICK);
	assign rise1 = start_button && !start_prev_q;
	assign rise2 = space_button && !space_prev_q;

	always_comb begin
		st_a   = st_q;
		len_a  = len_q;
		pose_a = pose_q;
		if (tick && rise1) begin
			case (st_q)
				S_IDLE: begin
					st_a   = S_REC;
					len_a  = '0;
					pose_a = GEST_NONE;
				end
				S_REC: begin
					st_a   = S_IDLE;
					len_a  = '0;
					pose_a = GEST_NONE;
				end
				default: ;
			endcase
		end
	end

	// a space right after a space ends the message
	assign sp_ev  = tick && rise2 && (st_a == S_REC);
	assign dbl    = sp_ev && (len_a != '0) && last_space_q;
	assign st_b   = dbl ? S_READY : st_a;
	assign pose_b = dbl ? GEST_NONE : pose_a;

	assign rec       = tick && (st_b == S_REC);
	assign filt_load = rec && sample_ok;
	assign sym_ev    = rec && (pose_new != GEST_NONE) && (pose_new != pose_b);
	assign sym_ch    = (pose_new == GEST_DOT) ? CH_DOT : CH_DASH;
	assign pose_n    = rec ? pose_new : pose_b;

	// slot 0 is always the first byte appended this tick
	assign c0_v = sp_ev || sym_ev;
	assign c0   = sp_ev ? CH_SPACE : sym_ch;
	assign c1_v = dbl || (sp_ev && sym_ev);
	assign c1   = dbl ? CH_NL : sym_ch;

	// appends are dropped once one slot short of the depth
	assign p0 = c0_v && (len_a < ADDR_W'(BUFFER_DEPTH - 1));
	assign p1 = c1_v && p0 && (len_a < ADDR_W'(BUFFER_DEPTH - 2));

	assign addr1 = len_a + ADDR_W'(1);
	assign len_c = len_a + ADDR_W'(p0) + ADDR_W'(p1);

	always_comb begin
		st_n  = st_b;
		len_n = len_c;
		if (accept && mode == MODE_SENT && st_q == S_READY) begin
			st_n  = S_IDLE;
			len_n = '0;
		end
	end

	assign last_space_n = p1 ? (c1 == CH_SPACE) : (p0 ? (c0 == CH_SPACE) : last_space_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			len_q        <= '0;
			pose_q       <= GEST_NONE;
			start_prev_q <= 1'b0;
			space_prev_q <= 1'b0;
			last_space_q <= 1'b0;
			fy_q         <= FY_RESET;
			fz_q         <= FZ_RESET;
		end else if (accept) begin
			st_q         <= st_n;
			len_q        <= len_n;
			pose_q       <= pose_n;
			last_space_q <= last_space_n;
			if (tick) begin
				start_prev_q <= start_button;
				space_prev_q <= space_button;
			end
			if (filt_load) begin
				fy_q <= fy_next;
				fz_q <= fz_next;
			end
		end
	end

	// the two bytes of one tick sit at consecutive addresses, so in different banks
	always_comb begin
		wr_even = '0;
		wr_odd  = '0;
		if (p0 && !len_a[0]) begin
			wr_even = '{en: 1'b1, addr: len_a[ADDR_W-1:1], data: c0};
		end else if (p1 && !addr1[0]) begin
			wr_even = '{en: 1'b1, addr: addr1[ADDR_W-1:1], data: c1};
		end
		if (p0 && len_a[0]) begin
			wr_odd = '{en: 1'b1, addr: len_a[ADDR_W-1:1], data: c0};
		end else if (p1 && addr1[0]) begin
			wr_odd = '{en: 1'b1, addr: addr1[ADDR_W-1:1], data: c1};
		end
	end

	assign idx_x     = IDX_XW'(read_index);
	assign rd_req.ok = (mode == MODE_READ) && (idx_x < IDX_XW'(len_q))
		&& (idx_x < IDX_XW'(BUFFER_DEPTH));
	assign rd_req.en   = accept && rd_req.ok;
	assign rd_req.addr = idx_x[ADDR_W-1:1];
	assign rd_req.sel  = idx_x[0];

	assign len_x               = IDX_XW'(len_n);
	assign res.app_state       = st_n;
	assign res.chars_added     = 2'(p0) + 2'(p1);
	assign res.first_char      = p0 ? c0 : '0;
	assign res.second_char     = p1 ? c1 : '0;
	assign res.message_length  = len_x[LEN_OUT_W-1:0];

endmodule

### rtl/core/tgm_checker.sv
// port-level checks on the recorder results, bound to the top level
module tgm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    app_state,
	input logic [1:0]                    chars_added,
	input logic [tgm_pkg::CHAR_W-1:0]    first_char,
	input logic [tgm_pkg::CHAR_W-1:0]    second_char,
	input logic [tgm_pkg::LEN_OUT_W-1:0] message_length,
	input logic [tgm_pkg::CHAR_W-1:0]    read_byte
);
	import tgm_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(app_state) && $stable(chars_added)
			&& $stable(first_char) && $stable(second_char) && $stable(message_length)
			&& $stable(read_byte))
		else $error("result changed while stalled");

	a_no_chars: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chars_added == 2'd0 |-> first_char == '0 && second_char == '0)
		else $error("character reported with nothing appended");

	a_one_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chars_added != 2'd2 |-> second_char == '0)
		else $error("second character without two appends");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && app_state == STATE_IDLE |-> message_length == '0)
		else $error("idle with bytes held");

	// appends only happen while recording or on the closing newline
	a_append_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chars_added != 2'd0 |-> app_state == STATE_REC || app_state == STATE_READY)
		else $error("append reported while idle");

endmodule

bind tilt_gesture_morse_recorder tgm_checker u_tgm_checker (.*);

### test/tilt_gesture_morse_recorder_tb.sv
// self-checking testbench for the tilt gesture morse recorder: directed and random requests
module tilt_gesture_morse_recorder_tb;
	import tgm_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 8;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam logic signed [SAMPLE_WIDTH-1:0] ONE_G    = 16'sd8192;
	localparam logic signed [SAMPLE_WIDTH-1:0] FULL_POS = 16'sh7FFF;
	localparam logic signed [SAMPLE_WIDTH-1:0] FULL_NEG = 16'sh8000;

	typedef struct packed {
		logic [MODE_W-1:0]              mode;
		logic signed [SAMPLE_WIDTH-1:0] accel_y;
		logic signed [SAMPLE_WIDTH-1:0] accel_z;
		logic                           sample_ok;
		logic                           start_button;
		logic                           space_button;
		logic [IDX_W-1:0]               read_index;
	} tilt_req_t;

	typedef struct packed {
		logic [1:0]           app_state;
		logic [1:0]           chars_added;
		logic [CHAR_W-1:0]    first_char;
		logic [CHAR_W-1:0]    second_char;
		logic [LEN_OUT_W-1:0] message_length;
		logic [CHAR_W-1:0]    read_byte;
	} tilt_res_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [MODE_W-1:0]              mode = MODE_TICK;
	logic signed [SAMPLE_WIDTH-1:0] accel_y = '0;
	logic signed [SAMPLE_WIDTH-1:0] accel_z = '0;
	logic                           sample_ok = 1'b0;
	logic                           start_button = 1'b0;
	logic                           space_button = 1'b0;
	logic [IDX_W-1:0]               read_index = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [1:0]                     app_state;
	logic [1:0]                     chars_added;
	logic [CHAR_W-1:0]              first_char;
	logic [CHAR_W-1:0]              second_char;
	logic [LEN_OUT_W-1:0]           message_length;
	logic [CHAR_W-1:0]              read_byte;
	logic                           cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]           cfg_index = '0;
	logic [CFG_W-1:0]               cfg_data = '0;

	tilt_gesture_morse_recorder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.sample_ok      (sample_ok),
		.start_button   (start_button),
		.space_button   (space_button),
		.read_index     (read_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.app_state      (app_state),
		.chars_added    (chars_added),
		.first_char     (first_char),
		.second_char    (second_char),
		.message_length (message_length),
		.read_byte      (read_byte),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted recorder state and register copies
	logic [THR_W-1:0]               thr_main  = MAIN_THR_RESET;
	logic [THR_W-1:0]               thr_ortho = ORTHO_THR_RESET;
	logic [ALPHA_W-1:0]             alpha_cfg = ALPHA_RESET;
	logic signed [SAMPLE_WIDTH-1:0] ema_y = FY_RESET;
	logic signed [SAMPLE_WIDTH-1:0] ema_z = FZ_RESET;
	pose_t                          prev_gest = GEST_NONE;
	logic                           start_prev = 1'b0;
	logic                           space_prev = 1'b0;
	logic [1:0]                     rec_state = STATE_IDLE;
	int                             held_len = 0;
	logic [CHAR_W-1:0]              msg_mem [BUFFER_DEPTH];
	int                             step_count;
	logic [CHAR_W-1:0]              step_chars [2];

	tilt_res_t morse_expected [$];

	bit          tx_gaps = 1'b1;
	bit          rx_gaps = 1'b1;
	bit          hold_trigger = 1'b0;
	bit          hold_seen = 1'b0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	pose_t       gest_kind = GEST_DOT;
	int unsigned reqs_sent = 0;
	int unsigned results_checked = 0;
	int unsigned fail_count = 0;
	int unsigned bytes_appended = 0;
	int unsigned messages_closed = 0;
	int unsigned settings_loaded = 0;

	function automatic logic signed [SAMPLE_WIDTH-1:0] ema_step(
		input logic signed [SAMPLE_WIDTH-1:0] prev,
		input logic signed [SAMPLE_WIDTH-1:0] x
	);
		longint a;
		longint acc;
		a = (alpha_cfg > ALPHA_FULL) ? 256 : longint'(alpha_cfg);
		acc = a * longint'(x) + (256 - a) * longint'(prev) + 128;
		return SAMPLE_WIDTH'(acc >>> 8);
	endfunction

	// bytes past the last free slot are dropped and not counted
	function automatic void append_char(input logic [CHAR_W-1:0] c);
		if (held_len + 1 < BUFFER_DEPTH) begin
			msg_mem[held_len] = c;
			held_len++;
			if (step_count < 2)
				step_chars[step_count] = c;
			step_count++;
		end
	endfunction

	function automatic tilt_res_t predict_morse(input tilt_req_t r);
		tilt_res_t   res;
		logic        rise_start;
		logic        rise_space;
		pose_t       pose;
		longint      mag_y;
		longint      mag_z;
		logic [7:0]  rbyte;
		rbyte = '0;
		step_count = 0;
		step_chars[0] = '0;
		step_chars[1] = '0;
		if (r.mode == MODE_TICK) begin
			rise_start = r.start_button && !start_prev;
			rise_space = r.space_button && !space_prev;
			start_prev = r.start_button;
			space_prev = r.space_button;
			// start is handled first, then space, then the tilt symbol
			if (rise_start && rec_state != STATE_READY) begin
				held_len = 0;
				prev_gest = GEST_NONE;
				rec_state = (rec_state == STATE_IDLE) ? STATE_REC : STATE_IDLE;
			end
			if (rise_space && rec_state == STATE_REC) begin
				if (held_len > 0 && msg_mem[held_len - 1] == CH_SPACE) begin
					append_char(CH_SPACE);
					append_char(CH_NL);
					rec_state = STATE_READY;
					prev_gest = GEST_NONE;
					messages_closed++;
				end else begin
					append_char(CH_SPACE);
				end
			end
			if (rec_state == STATE_REC) begin
				if (r.sample_ok) begin
					ema_y = ema_step(ema_y, r.accel_y);
					ema_z = ema_step(ema_z, r.accel_z);
				end
				mag_y = longint'(ema_y);
				mag_z = longint'(ema_z);
				if (mag_y < 0)
					mag_y = -mag_y;
				if (mag_z < 0)
					mag_z = -mag_z;
				pose = GEST_NONE;
				if (mag_z > longint'(thr_main) && mag_y < longint'(thr_ortho))
					pose = GEST_DOT;
				else if (mag_y > longint'(thr_main) && mag_z < longint'(thr_ortho))
					pose = GEST_DASH;
				if (pose != GEST_NONE && pose != prev_gest)
					append_char((pose == GEST_DOT) ? CH_DOT : CH_DASH);
				prev_gest = pose;
			end
		end else if (r.mode == MODE_READ) begin
			if (int'(r.read_index) < held_len)
				rbyte = msg_mem[r.read_index];
		end else if (r.mode == MODE_SENT) begin
			if (rec_state == STATE_READY) begin
				held_len = 0;
				rec_state = STATE_IDLE;
			end
		end
		bytes_appended += step_count;
		res.app_state      = rec_state;
		res.chars_added    = (step_count > 2) ? 2'd2 : 2'(step_count);
		res.first_char     = step_chars[0];
		res.second_char    = step_chars[1];
		res.message_length = LEN_OUT_W'(held_len);
		res.read_byte      = rbyte;
		return res;
	endfunction

	function automatic tilt_req_t random_req(input logic [MODE_W-1:0] m);
		tilt_req_t r;
		r.mode         = m;
		r.accel_y      = SAMPLE_WIDTH'($urandom);
		r.accel_z      = SAMPLE_WIDTH'($urandom);
		r.sample_ok    = 1'($urandom);
		r.start_button = 1'($urandom);
		r.space_button = 1'($urandom);
		r.read_index   = IDX_W'($urandom);
		return r;
	endfunction

	function automatic tilt_req_t make_tick(
		input logic signed [SAMPLE_WIDTH-1:0] ay,
		input logic signed [SAMPLE_WIDTH-1:0] az,
		input logic ok,
		input logic b1,
		input logic b2
	);
		tilt_req_t r;
		r = random_req(MODE_TICK);
		r.accel_y      = ay;
		r.accel_z      = az;
		r.sample_ok    = ok;
		r.start_button = b1;
		r.space_button = b2;
		return r;
	endfunction

	function automatic tilt_req_t make_read(input logic [IDX_W-1:0] idx);
		tilt_req_t r;
		r = random_req(MODE_READ);
		r.read_index = idx;
		return r;
	endfunction

	// tick with both buttons released and samples leaning towards one pose, or random samples for no pose
	function automatic tilt_req_t pose_tick(input pose_t kind);
		logic signed [SAMPLE_WIDTH-1:0] major;
		logic signed [SAMPLE_WIDTH-1:0] minor;
		logic                           ok;
		major = SAMPLE_WIDTH'($urandom_range(6500, 12000));
		minor = SAMPLE_WIDTH'($urandom_range(0, 2000));
		ok = ($urandom_range(9) != 0);
		if ($urandom_range(1))
			major = -major;
		if ($urandom_range(1))
			minor = -minor;
		if ($urandom_range(15) == 0)
			major = $urandom_range(1) ? FULL_POS : FULL_NEG;
		case (kind)
			GEST_DOT:  return make_tick(minor, major, ok, 1'b0, 1'b0);
			GEST_DASH: return make_tick(major, minor, ok, 1'b0, 1'b0);
			default:   return make_tick(SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom),
					ok, 1'b0, 1'b0);
		endcase
	endfunction

	// valid stays high after acceptance until the next call inserts a gap or a drain lowers it
	task automatic send_request(input tilt_req_t r);
		while (tx_gaps && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= r.mode;
		accel_y      <= r.accel_y;
		accel_z      <= r.accel_z;
		sample_ok    <= r.sample_ok;
		start_button <= r.start_button;
		space_button <= r.space_button;
		read_index   <= r.read_index;
		do begin
			@(posedge clk);
		end while (!in_ready);
		morse_expected.push_back(predict_morse(r));
		reqs_sent++;
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (morse_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_config(
		input logic [THR_W-1:0]   main_v,
		input logic [THR_W-1:0]   ortho_v,
		input logic [ALPHA_W-1:0] alpha_v
	);
		wait_results_done();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAIN_THRESHOLD;
		cfg_data  <= CFG_W'(main_v);
		@(posedge clk);
		cfg_index <= REG_ORTHO_THRESHOLD;
		cfg_data  <= CFG_W'(ortho_v);
		@(posedge clk);
		cfg_index <= REG_FILTER_ALPHA;
		cfg_data  <= CFG_W'(alpha_v);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		thr_main  = main_v;
		thr_ortho = ortho_v;
		alpha_cfg = alpha_v;
		settings_loaded++;
	endtask

	// one request shaped by the predicted state: mostly well-formed sessions, some noise
	task automatic session_step();
		tilt_req_t r;
		int        pick;
		pick = $urandom_range(99);
		if ($urandom_range(7) == 0)
			gest_kind = pose_t'($urandom_range(2));
		r = pose_tick(gest_kind);
		if (pick < 8) begin
			r = random_req(MODE_W'($urandom_range(2)));
		end else if (rec_state == STATE_IDLE) begin
			if (pick < 30)
				r = make_read(IDX_W'($urandom));
			else if (!start_prev)
				r.start_button = 1'b1;
		end else if (rec_state == STATE_REC) begin
			if (pick < 16)
				r.space_button = !space_prev;
			else if (pick < 18)
				r.start_button = !start_prev;
			else if (pick < 26)
				r = make_read(IDX_W'($urandom_range(0, (held_len < 125) ? held_len + 2 : 127)));
		end else begin
			if (pick < 45)
				r = make_read(IDX_W'($urandom_range(0, held_len + 2)));
			else if (pick < 70)
				r = random_req(MODE_SENT);
			else
				r = random_req(MODE_TICK);
		end
		send_request(r);
	endtask

	task automatic test_directed();
		tilt_req_t r;
		send_request(make_read('0));
		send_request(make_read('1));
		send_request(random_req(MODE_SENT));
		r = random_req(MODE_SPARE);
		send_request(r);
		// start with full-scale samples of opposite sign
		send_request(make_tick(FULL_POS, FULL_NEG, 1'b1, 1'b1, 1'b0));
		send_request(make_tick(FULL_NEG, FULL_POS, 1'b0, 1'b0, 1'b0));
		repeat (4) send_request(make_tick('0, FULL_NEG, 1'b1, 1'b0, 1'b0));
		repeat (6) send_request(make_tick(FULL_POS, '0, 1'b1, 1'b0, 1'b0));
		send_request(make_tick(FULL_POS, '0, 1'b1, 1'b0, 1'b1));
		// cancel, then start and space in the same tick
		send_request(make_tick(FULL_POS, '0, 1'b0, 1'b1, 1'b0));
		send_request(make_tick(FULL_POS, '0, 1'b0, 1'b0, 1'b0));
		send_request(make_tick(FULL_POS, '0, 1'b0, 1'b1, 1'b1));
		send_request(make_tick('0, '0, 1'b0, 1'b0, 1'b0));
		send_request(make_tick('0, '0, 1'b0, 1'b0, 1'b1));
		send_request(make_tick('0, '0, 1'b0, 1'b0, 1'b0));
		send_request(make_tick('0, '0, 1'b0, 1'b0, 1'b1));
		// buttons are ignored once the message is ready
		send_request(make_tick('0, ONE_G, 1'b1, 1'b1, 1'b1));
		send_request(make_read('0));
		send_request(make_read(IDX_W'(1)));
		send_request(random_req(MODE_SENT));
		send_request(random_req(MODE_SENT));
	endtask

	task automatic test_config_extremes();
		load_config('0, '1, ALPHA_FULL);
		repeat (60) session_step();
		load_config('1, '0, '0);
		repeat (60) session_step();
		// alpha above full weight behaves as full weight
		load_config('1, '1, '1);
		repeat (60) session_step();
		load_config(THR_W'(1), THR_W'(1), ALPHA_W'(1));
		repeat (60) session_step();
		repeat (2) begin
			load_config(THR_W'($urandom_range(3000, 12000)), THR_W'($urandom_range(500, 6000)),
				ALPHA_W'($urandom_range(1, 300)));
			repeat (60) session_step();
		end
	endtask

	task automatic test_full_buffer();
		load_config(MAIN_THR_RESET, ORTHO_THR_RESET, ALPHA_FULL);
		// first message closes with room for its space but not its newline, second runs past the end
		for (int i = 0; i < 2; i++) begin
			if (rec_state == STATE_READY)
				send_request(random_req(MODE_SENT));
			while (rec_state == STATE_REC)
				send_request(make_tick('0, ONE_G, 1'b0, !start_prev, 1'b0));
			while (rec_state != STATE_REC)
				send_request(make_tick('0, ONE_G, 1'b0, !start_prev, 1'b0));
			for (int n = 0; (i == 0) ? (held_len < BUFFER_DEPTH - 3) : (n < BUFFER_DEPTH + 12);
					n++)
				send_request(make_tick(n[0] ? ONE_G : '0, n[0] ? '0 : ONE_G, 1'b1, 1'b0, 1'b0));
			if (i == 1) begin
				for (int k = 0; k < BUFFER_DEPTH; k++)
					send_request(make_read(IDX_W'(k)));
			end
			send_request(make_tick('0, '0, 1'b0, 1'b0, 1'b1));
			send_request(make_tick('0, '0, 1'b0, 1'b0, 1'b0));
			send_request(make_tick('0, '0, 1'b0, 1'b0, 1'b1));
			send_request(make_read(IDX_W'(BUFFER_DEPTH - 2)));
		end
	endtask

	task automatic test_back_to_back();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		repeat (150) session_step();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	task automatic test_receiver_hold();
		tx_gaps = 1'b0;
		hold_trigger <= !hold_trigger;
		repeat (60) session_step();
		tx_gaps = 1'b1;
	endtask

	task automatic test_random();
		load_config(MAIN_THR_RESET, ORTHO_THR_RESET, ALPHA_RESET);
		repeat (100) session_step();
	endtask

	always @(posedge clk) begin : drive_out_ready
		if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(rx_gaps && $urandom_range(99) < 20);
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		tilt_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (morse_expected.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = morse_expected.pop_front();
				check_field("app_state", CHAR_W'(want.app_state), CHAR_W'(app_state));
				check_field("chars_added", CHAR_W'(want.chars_added), CHAR_W'(chars_added));
				check_field("first_char", want.first_char, first_char);
				check_field("second_char", want.second_char, second_char);
				check_field("message_length", CHAR_W'(want.message_length),
					CHAR_W'(message_length));
				check_field("read_byte", want.read_byte, read_byte);
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tilt_gesture_morse_recorder_tb: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_full_buffer();
		test_back_to_back();
		test_receiver_hold();
		test_random();
		wait_results_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests, %0d results checked, %0d register settings",
			reqs_sent, results_checked, settings_loaded);
		$display("%0d message bytes appended, %0d messages closed, full buffer and long stall",
			bytes_appended, messages_closed);
		if (fail_count == 0 && morse_expected.size() == 0)
			$display("tilt_gesture_morse_recorder_tb: PASS");
		else
			$display("tilt_gesture_morse_recorder_tb: FAIL");
		$finish;
	end

endmodule
